[hdl/sitoa_pkg.sv]
// ----------------------------------------------------------------------------
// sitoa_pkg
// shared constants and controller/datapath handshake types for the signed
// integer to decimal text converter
// ----------------------------------------------------------------------------
package sitoa_pkg;

  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned PROD_W         = 2 * VALUE_W;
  localparam int unsigned MAX_DIGITS_DEF = 10;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  // x / 10 == (x * RECIP10) >> DIV_SHIFT, exact for every 32-bit x
  localparam logic [VALUE_W-1:0] RECIP10   = 32'hCCCC_CCCD;
  localparam int unsigned        DIV_SHIFT = 35;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture input beat, form magnitude
    logic mul;         // first reciprocal product from magnitude
    logic div_step;    // store one digit, advance quotient
    logic emit_minus;  // load '-' into output register
    logic emit_digit;  // load next digit into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic neg;         // captured value was negative
    logic div_last;    // current division step is the final one
    logic ptr_zero;    // digit pointer at least significant digit
    logic out_free;    // output register can take a character
  } sts_t;

endpackage

[hdl/sitoa_dp.sv]
// ----------------------------------------------------------------------------
// sitoa_dp
// datapath: magnitude, reciprocal divider by ten, digit store and output
// register
// ----------------------------------------------------------------------------
module sitoa_dp #(
  parameter int unsigned MAX_DIGITS = sitoa_pkg::MAX_DIGITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [sitoa_pkg::VALUE_W-1:0] value_i,
  input  sitoa_pkg::cmd_t                      cmd_i,
  output sitoa_pkg::sts_t                      sts_o,
  input  logic                                 stall_i,
  output logic                                 valid_o,
  output logic        [sitoa_pkg::CHAR_W-1:0]  ascii_char_o,
  output logic                                 last_char_o
);
  import sitoa_pkg::*;

  localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_DIGITS - 1);

  logic [VALUE_W-1:0] mag_q, mag_d;
  logic [PROD_W-1:0]  prod_q;
  logic [IDX_W-1:0]   ptr_q;
  logic               neg_q;
  logic [DIGIT_W-1:0] store_q [MAX_DIGITS];
  logic               valid_q;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;

  logic [VALUE_W-1:0] raw;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] quot_x10;
  logic [VALUE_W-1:0] rem_full;
  logic [DIGIT_W-1:0] rem;
  logic [VALUE_W-1:0] mul_in;
  logic [PROD_W-1:0]  prod_d;
  logic               div_last;
  logic               out_free;

  assign raw      = VALUE_W'(value_i);
  assign mag_d    = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
  assign quot     = VALUE_W'(prod_q >> DIV_SHIFT);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem_full = mag_q - quot_x10;
  assign rem      = rem_full[DIGIT_W-1:0];
  assign mul_in   = cmd_i.mul ? mag_q : quot;
  assign prod_d   = PROD_W'(mul_in) * PROD_W'(RECIP10);
  assign div_last = (quot == '0) || (ptr_q == LAST_IDX);
  assign out_free = !valid_q || !stall_i;

  assign sts_o.neg      = neg_q;
  assign sts_o.div_last = div_last;
  assign sts_o.ptr_zero = (ptr_q == '0);
  assign sts_o.out_free = out_free;

  // magnitude, quotient product and digit store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= mag_d;
      neg_q <= raw[VALUE_W-1];
      ptr_q <= '0;
    end else if (cmd_i.div_step) begin
      mag_q          <= quot;
      store_q[ptr_q] <= rem;
      if (!div_last) begin
        ptr_q <= ptr_q + IDX_W'(1);
      end
    end else if (cmd_i.emit_digit && (ptr_q != '0)) begin
      ptr_q <= ptr_q - IDX_W'(1);
    end
    if (cmd_i.mul || cmd_i.div_step) begin
      prod_q <= prod_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.emit_minus || cmd_i.emit_digit) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_minus) begin
      char_q <= CHAR_MINUS;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= CHAR_ZERO + CHAR_W'(store_q[ptr_q]);
      last_q <= (ptr_q == '0);
    end
  end

  assign valid_o      = valid_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;

`ifndef ASSERT_OFF
  a_last_is_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && last_q |-> char_q != CHAR_MINUS)
    else $error("minus sign marked as last character");

  a_load_clears_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> ptr_q == '0)
    else $error("digit pointer not cleared on new value");

  a_stalled_beat_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && stall_i |=> valid_q && $stable(char_q) && $stable(last_q))
    else $error("stalled output beat changed");
`endif

endmodule

[hdl/sitoa_ctrl.sv]
// ----------------------------------------------------------------------------
// sitoa_ctrl
// controller: sequences capture, division by ten and character readout
// ----------------------------------------------------------------------------
module sitoa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  output sitoa_pkg::cmd_t cmd_o,
  input  sitoa_pkg::sts_t sts_i
);
  import sitoa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_MINUS,
    ST_DIGITS
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = sts_i.neg ? ST_MINUS : ST_DIGITS;
        end
      end
      ST_MINUS: begin
        if (sts_i.out_free) begin
          cmd_o.emit_minus = 1'b1;
          state_d          = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (sts_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.ptr_zero) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign stall_o = (state_q != ST_IDLE);

`ifndef ASSERT_OFF
  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_minus || cmd_o.emit_digit) |-> sts_i.out_free)
    else $error("character loaded while output register busy");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> state_q == ST_MUL)
    else $error("accepted beat did not start a conversion");

  a_minus_only_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MINUS |-> sts_i.neg)
    else $error("minus sign for a non-negative value");
`endif

endmodule

[hdl/signed_int_to_decimal_ascii_top.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// signed 32-bit integer to decimal ascii text, one character per output beat
// ----------------------------------------------------------------------------
//
//   channel  signals                                   dir  beat
//   -------  ----------------------------------------  ---  -------------------
//   input    valid_i, stall_o, value_i[31:0]           in   one number
//   output   valid_o, stall_i, ascii_char_o[7:0],      out  one character,
//            last_char_o                                    last marks the end
//
// sequence: capture, first product, then one divide step per digit (one digit
//   a cycle from the single reciprocal multiplier), then readout of one character
//   a cycle while stall_i is low, with '-' first for negatives
// reset: asynchronous, active low; clears controller state and output valid
// stalls: stall_i holds the output register and pauses readout; stall_o is
//   high from capture until the last character enters the output register
//
module signed_int_to_decimal_ascii_top #(
  parameter int unsigned MAX_DIGITS = sitoa_pkg::MAX_DIGITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input beat
  input  logic                                 valid_i,
  output logic                                 stall_o,
  input  logic signed [sitoa_pkg::VALUE_W-1:0] value_i,
  // output beat
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic        [sitoa_pkg::CHAR_W-1:0]  ascii_char_o,
  output logic                                 last_char_o
);
  import sitoa_pkg::*;

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: idle, product, divide, sign, digit readout
  sitoa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  // magnitude, divide by ten, digit store, output register
  sitoa_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .stall_i      (stall_i),
    .valid_o      (valid_o),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o)
  );

endmodule
